### rtl/nearest_palette_color_search_core_macros.svh
// Assertion macros for the nearest palette color search core.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_CORE_MACROS_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define NPCS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define NPCS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/npcs_pkg.sv
// Shared types, constants and helper functions for the nearest palette color search.
// Used by npcs_dist_unit and nearest_palette_color_search_core; depends on nothing.
`timescale 1ns / 1ps

package npcs_pkg;

    // Field widths of the input and result beats.
    localparam int COLOR_W   = 24;
    localparam int CHAN_W    = 8;
    localparam int SQ_W      = 2 * CHAN_W;
    localparam int DIST_W    = 18;
    localparam int INDEX_W   = 8;
    localparam int COUNT_W   = 9;

    // Default palette depth and reset value of the entry count register.
    localparam int               PALETTE_DEPTH_DEF = 256;
    localparam logic [COUNT_W-1:0] COUNT_RESET     = 9'd16;

    // Command codes carried by an input beat.
    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // Absolute difference of two color channels.
    function automatic logic [CHAN_W-1:0] chan_absdiff(input logic [CHAN_W-1:0] a,
                                                       input logic [CHAN_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

### rtl/npcs_dist_unit.sv
// Two-stage squared Euclidean distance unit for one pair of RGB colors.
// Depends on npcs_pkg for widths and the channel difference helper.
`timescale 1ns / 1ps

module npcs_dist_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  logic [npcs_pkg::COLOR_W-1:0]  color_a,
    input  logic [npcs_pkg::COLOR_W-1:0]  color_b,
    output logic                          out_valid,
    output logic [npcs_pkg::DIST_W-1:0]   distance
);

    logic [npcs_pkg::CHAN_W-1:0] diff_r, diff_g, diff_b;
    logic [npcs_pkg::SQ_W-1:0]   sq_r_reg, sq_g_reg, sq_b_reg;
    logic                        sq_valid_reg;
    logic [npcs_pkg::DIST_W-1:0] sum_reg;
    logic                        sum_valid_reg;

    // Per-channel absolute differences.
    assign diff_r = npcs_pkg::chan_absdiff(color_a[23:16], color_b[23:16]);
    assign diff_g = npcs_pkg::chan_absdiff(color_a[15:8], color_b[15:8]);
    assign diff_b = npcs_pkg::chan_absdiff(color_a[7:0], color_b[7:0]);

    // Stage one squares each channel difference.
    always_ff @(posedge aclk) begin
        sq_r_reg <= diff_r * diff_r;
        sq_g_reg <= diff_g * diff_g;
        sq_b_reg <= diff_b * diff_b;
    end

    // Stage two adds the three squares.
    always_ff @(posedge aclk) begin
        sum_reg <= npcs_pkg::DIST_W'(sq_r_reg) + npcs_pkg::DIST_W'(sq_g_reg)
                 + npcs_pkg::DIST_W'(sq_b_reg);
    end

    // Valid flags follow the data through both stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end else begin
            sq_valid_reg  <= in_valid;
            sum_valid_reg <= sq_valid_reg;
        end
    end

    assign out_valid = sum_valid_reg;
    assign distance  = sum_reg;

endmodule

### rtl/nearest_palette_color_search_core.sv
// A query is accepted only while idle; the scan then reads one palette entry per cycle from
// the one read port of the palette memory into the single distance unit, and the result beat
// follows once all N entries, N the effective entry count, were compared.
// Loads are written when accepted; a finished result waits in an output register.
// Reset (aresetn, synchronous, active low) clears control state and sets entry_count to 16;
// palette contents are undefined until loaded.
`timescale 1ns / 1ps
`include "nearest_palette_color_search_core_macros.svh"

module nearest_palette_color_search_core #(
    parameter int PALETTE_DEPTH = npcs_pkg::PALETTE_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration write channel.
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [npcs_pkg::COUNT_W-1:0]   cfg_entry_count,
    // Input beat channel.
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_command,
    input  logic [npcs_pkg::INDEX_W-1:0]   s_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]   s_color,
    // Result beat channel.
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [npcs_pkg::INDEX_W-1:0]   m_best_index,
    output logic [npcs_pkg::DIST_W-1:0]    m_best_distance
);

    localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int CW = $clog2(PALETTE_DEPTH + 1);
    localparam int IW = (AW > npcs_pkg::INDEX_W) ? AW : npcs_pkg::INDEX_W;
    localparam int NW = (CW > npcs_pkg::COUNT_W) ? CW : npcs_pkg::COUNT_W;

    npcs_pkg::state_t state_reg, state_next;

    logic [npcs_pkg::COUNT_W-1:0] entry_count_reg;
    logic [CW-1:0]                n_reg, n_next, n_eff;
    logic [CW-1:0]                issue_cnt_reg, issue_cnt_next;
    logic [CW-1:0]                res_cnt_reg, res_cnt_next;
    logic [npcs_pkg::COLOR_W-1:0] q_color_reg;
    logic [AW-1:0]                best_idx_reg, best_idx_next;
    logic [npcs_pkg::DIST_W-1:0]  best_dist_reg, best_dist_next;
    logic                         m_valid_reg, m_valid_next;
    logic [IW-1:0]                m_idx_reg, m_idx_next;
    logic [npcs_pkg::DIST_W-1:0]  m_dist_reg, m_dist_next;

    logic                         s_accept;
    logic                         load_we;
    logic [IW-1:0]                slot_ext;
    logic [NW-1:0]                cnt_ext;
    logic                         rd_en;
    logic [npcs_pkg::COLOR_W-1:0] rd_data_reg;
    logic                         rd_valid_reg;
    logic                         dist_valid;
    logic [npcs_pkg::DIST_W-1:0]  dist_value;

    logic [npcs_pkg::COLOR_W-1:0] pal_mem [PALETTE_DEPTH];

    // Configuration is always taken; a query latches the count when it is accepted.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_count_reg <= npcs_pkg::COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            entry_count_reg <= cfg_entry_count;
        end
    end

    // Effective entry count: zero searches one entry, large values saturate.
    assign cnt_ext = NW'(entry_count_reg);
    always_comb begin
        if (cnt_ext == '0) begin
            n_eff = CW'(1);
        end else if (cnt_ext > NW'(PALETTE_DEPTH)) begin
            n_eff = CW'(PALETTE_DEPTH);
        end else begin
            n_eff = CW'(cnt_ext);
        end
    end

    assign s_ready  = (state_reg == npcs_pkg::ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign slot_ext = IW'(s_entry_index);
    assign load_we  = s_accept && (s_command == npcs_pkg::CMD_LOAD)
                   && ({1'b0, slot_ext} < (IW + 1)'(PALETTE_DEPTH));

    // Issue one read per cycle while entries remain to be scanned.
    assign rd_en = (state_reg == npcs_pkg::ST_SCAN) && (issue_cnt_reg < n_reg);

    // Palette memory: one write port for loads, one registered read port for the scan.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            pal_mem[slot_ext[AW-1:0]] <= s_color;
        end
        if (rd_en) begin
            rd_data_reg <= pal_mem[issue_cnt_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_en;
        end
    end

    // Query color is held for the whole scan.
    always_ff @(posedge aclk) begin
        if (s_accept && (s_command == npcs_pkg::CMD_QUERY)) begin
            q_color_reg <= s_color;
        end
    end

    npcs_dist_unit u_dist (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .color_a   (q_color_reg),
        .color_b   (rd_data_reg),
        .out_valid (dist_valid),
        .distance  (dist_value)
    );

    // State register and scan bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= npcs_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            issue_cnt_reg <= '0;
            res_cnt_reg   <= '0;
        end else begin
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
            issue_cnt_reg <= issue_cnt_next;
            res_cnt_reg   <= res_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg         <= n_next;
        best_idx_reg  <= best_idx_next;
        best_dist_reg <= best_dist_next;
        m_idx_reg     <= m_idx_next;
        m_dist_reg    <= m_dist_next;
    end

    // Sequencer: next state, running best and output register.
    always_comb begin
        state_next     = state_reg;
        n_next         = n_reg;
        issue_cnt_next = issue_cnt_reg;
        res_cnt_next   = res_cnt_reg;
        best_idx_next  = best_idx_reg;
        best_dist_next = best_dist_reg;
        m_valid_next   = m_valid_reg;
        m_idx_next     = m_idx_reg;
        m_dist_next    = m_dist_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            npcs_pkg::ST_IDLE: begin
                if (s_accept && (s_command == npcs_pkg::CMD_QUERY)) begin
                    n_next         = n_eff;
                    issue_cnt_next = '0;
                    res_cnt_next   = '0;
                    state_next     = npcs_pkg::ST_SCAN;
                end
            end
            npcs_pkg::ST_SCAN: begin
                if (rd_en) begin
                    issue_cnt_next = issue_cnt_reg + CW'(1);
                end
                if (dist_valid) begin
                    // Only a strictly smaller distance replaces the best, so ties keep
                    // the lowest index.
                    if ((res_cnt_reg == '0) || (dist_value < best_dist_reg)) begin
                        best_idx_next  = res_cnt_reg[AW-1:0];
                        best_dist_next = dist_value;
                    end
                    res_cnt_next = res_cnt_reg + CW'(1);
                    if (res_cnt_reg == n_reg - CW'(1)) begin
                        state_next = npcs_pkg::ST_FINISH;
                    end
                end
            end
            npcs_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = IW'(best_idx_reg);
                    m_dist_next  = best_dist_reg;
                    state_next   = npcs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_best_index    = m_idx_reg[npcs_pkg::INDEX_W-1:0];
    assign m_best_distance = m_dist_reg;

    // Reads never run past the effective count.
    `NPCS_ASSERT_IMP(a_issue_bound, aclk, aresetn, state_reg == npcs_pkg::ST_SCAN, issue_cnt_reg <= n_reg, "scan issued past the entry count")

    // Every distance that arrives belongs to a read already issued.
    `NPCS_ASSERT_IMP(a_result_order, aclk, aresetn, dist_valid && (state_reg == npcs_pkg::ST_SCAN), res_cnt_reg < issue_cnt_reg, "distance arrived without a matching read")

    // The finish state is reached only after all entries were compared.
    `NPCS_ASSERT_IMP(a_finish_count, aclk, aresetn, state_reg == npcs_pkg::ST_FINISH, res_cnt_reg == n_reg, "scan finished before all entries were compared")

    // The running best distance never grows during a scan.
    `NPCS_ASSERT_NXT(a_best_monotonic, aclk, aresetn, (state_reg == npcs_pkg::ST_SCAN) && dist_valid && (res_cnt_reg != '0), best_dist_reg <= $past(best_dist_reg), "best distance increased")

endmodule
